// File: sv/tmer_pkg.sv
// package: shared types, codes and constants of the tilemap edge and row renderer
`default_nettype none
package tmer_pkg;

	localparam int MAP_COLS_DEF    = 96;
	localparam int MAP_ROWS_DEF    = 48;
	localparam int VIEW_HEIGHT_DEF = 64;
	localparam int VIEW_COLS_DEF   = 32;

	localparam int TILE_SIZE = 2048;
	localparam int TILE_AW   = 11;

	localparam logic [2:0] FUNC_WR_MAP    = 3'd0;
	localparam logic [2:0] FUNC_WR_TILE   = 3'd1;
	localparam logic [2:0] FUNC_EDGE_LEFT = 3'd2;
	localparam logic [2:0] FUNC_EDGE_RGHT = 3'd3;
	localparam logic [2:0] FUNC_ROW       = 3'd4;

	localparam logic CFG_START_ROW  = 1'b0;
	localparam logic CFG_COL_OFFSET = 1'b1;

	localparam logic [4:0] START_ROW_RST = 5'd4;
	localparam logic [4:0] COL_OFFSET_RST = 5'd0;

	localparam logic [7:0] LEFT_PIX_MASK  = 8'hC0;
	localparam logic [7:0] RIGHT_PIX_MASK = 8'h03;
	localparam logic [7:0] LEFT_KEEP      = 8'h3F;
	localparam logic [7:0] RIGHT_KEEP     = 8'hFC;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_ROW  = 1'b1;

	typedef struct packed {
		logic [2:0]  func;
		logic [12:0] table_addr;
		logic [7:0]  write_data;
		logic [9:0]  view_x;
		logic [7:0]  view_y;
		logic [6:0]  first_col;
		logic [5:0]  row_tile;
		logic [2:0]  row_line;
	} op_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] screen_addr;
		logic [5:0]  buffer_col;
		logic [7:0]  pixel_data;
		logic [7:0]  keep_mask;
		logic        last;
	} result_t;

	typedef struct packed {
		logic wr_map;
		logic wr_tile;
		logic load;
		logic map_rd;
		logic tile_rd;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_line;
	} dp_status_t;

endpackage
`default_nettype wire

// File: sv/tmer_ctrl.sv
// controller state machine: accepts items and sequences map read, tile read and result per line
`default_nettype none
module tmer_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [2:0]            func,
	input  tmer_pkg::dp_status_t  status,
	output tmer_pkg::dp_cmd_t     cmd,
	output logic                  busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAP  = 2'd1;
	localparam logic [1:0] S_TILE = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       is_render;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign is_render = (func == tmer_pkg::FUNC_EDGE_LEFT) || (func == tmer_pkg::FUNC_EDGE_RGHT)
		|| (func == tmer_pkg::FUNC_ROW);

	always_comb begin
		cmd.wr_map  = accept && (func == tmer_pkg::FUNC_WR_MAP);
		cmd.wr_tile = accept && (func == tmer_pkg::FUNC_WR_TILE);
		cmd.load    = accept && is_render;
		cmd.map_rd  = (state_q == S_MAP);
		cmd.tile_rd = (state_q == S_TILE);
		cmd.emit    = (state_q == S_OUT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_render) begin
					state_d = S_MAP;
				end
			end
			S_MAP:  state_d = S_TILE;
			S_TILE: state_d = S_OUT;
			S_OUT: begin
				state_d = status.last_line ? S_IDLE : S_MAP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_map_then_tile: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_rd |=> cmd.tile_rd)
		else $error("map read not followed by tile read");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && status.last_line |=> !busy)
		else $error("still busy after last line");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy && cmd.map_rd)
		else $error("render command did not start");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !(cmd.map_rd || cmd.tile_rd || cmd.emit))
		else $error("datapath step while idle");

endmodule
`default_nettype wire

// File: sv/tmer_datapath.sv
// datapath: map and tile stores, command registers, line counter and result register
`default_nettype none
module tmer_datapath #(
	parameter int MAP_COLS    = tmer_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS    = tmer_pkg::MAP_ROWS_DEF,
	parameter int VIEW_HEIGHT = tmer_pkg::VIEW_HEIGHT_DEF,
	parameter int VIEW_COLS   = tmer_pkg::VIEW_COLS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tmer_pkg::op_t         op,
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire  [4:0]            cfg_data,
	input  tmer_pkg::dp_cmd_t     cmd,
	output tmer_pkg::dp_status_t  status,
	output tmer_pkg::result_t     result,
	output logic                  result_strobe
);

	localparam int MAP_SIZE = MAP_COLS * MAP_ROWS;
	localparam int MAP_AW   = $clog2(MAP_SIZE);
	localparam int CNT_MAX  = (VIEW_HEIGHT - 1 > VIEW_COLS) ? VIEW_HEIGHT - 1 : VIEW_COLS;
	localparam int CNT_W    = $clog2(CNT_MAX + 1);

	logic [7:0] map_mem  [0:MAP_SIZE-1];
	logic [7:0] tile_mem [0:tmer_pkg::TILE_SIZE-1];

	logic [4:0]        start_row_q;
	logic [4:0]        col_off_q;
	logic              is_row_q;
	logic              is_right_q;
	logic [10:0]       px_q;
	logic [7:0]        camy_q;
	logic [6:0]        scol_q;
	logic [5:0]        rtile_q;
	logic [2:0]        rline_q;
	logic [CNT_W-1:0]  idx_q;
	logic [7:0]        map_q;
	logic [7:0]        tile_q;
	tmer_pkg::result_t result_q;
	logic              strobe_q;

	logic [10:0]       px_d;
	logic [7:0]        my;
	logic [7:0]        row_raw;
	logic [7:0]        col_raw;
	logic [7:0]        row_c;
	logic [7:0]        col_c;
	logic [2:0]        line_sel;
	logic [MAP_AW-1:0] map_rd_addr;
	logic [2:0]        sub;
	logic [7:0]        scr_y;
	logic [15:0]       scr_base;
	logic [5:0]        bcol;
	logic              last_line;
	tmer_pkg::result_t res_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= tmer_pkg::START_ROW_RST;
			col_off_q   <= tmer_pkg::COL_OFFSET_RST;
		end else if (cfg_we) begin
			if (cfg_index == tmer_pkg::CFG_START_ROW) begin
				start_row_q <= cfg_data;
			end else if (cfg_index == tmer_pkg::CFG_COL_OFFSET) begin
				col_off_q <= cfg_data;
			end
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (cmd.wr_map && (32'(op.table_addr) < MAP_SIZE)) begin
			map_mem[MAP_AW'(op.table_addr)] <= op.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_tile && (op.table_addr[12:tmer_pkg::TILE_AW] == '0)) begin
			tile_mem[op.table_addr[tmer_pkg::TILE_AW-1:0]] <= op.write_data;
		end
	end

	// command registers
	assign px_d = (op.func == tmer_pkg::FUNC_EDGE_RGHT)
		? 11'({op.view_x[9:1], 1'b0}) + 11'(VIEW_COLS * 8 - 2)
		: 11'({op.view_x[9:1], 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_row_q   <= (op.func == tmer_pkg::FUNC_ROW);
			is_right_q <= (op.func == tmer_pkg::FUNC_EDGE_RGHT);
			px_q       <= px_d;
			camy_q     <= op.view_y;
			scol_q     <= op.first_col;
			rtile_q    <= op.row_tile;
			rline_q    <= op.row_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// map position of the current line
	assign my       = camy_q + 8'(idx_q);
	assign row_raw  = is_row_q ? 8'(rtile_q) : 8'(my[7:3]);
	assign col_raw  = is_row_q ? (8'(scol_q) + 8'(idx_q)) : px_q[10:3];
	assign row_c    = (row_raw > 8'(MAP_ROWS - 1)) ? 8'(MAP_ROWS - 1) : row_raw;
	assign col_c    = (col_raw > 8'(MAP_COLS - 1)) ? 8'(MAP_COLS - 1) : col_raw;
	assign line_sel = is_row_q ? rline_q : my[2:0];
	assign map_rd_addr = MAP_AW'(row_c) * MAP_AW'(MAP_COLS) + MAP_AW'(col_c);

	always_ff @(posedge clk) begin
		if (cmd.map_rd) begin
			map_q <= map_mem[map_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tile_rd) begin
			tile_q <= tile_mem[{map_q, line_sel}];
		end
	end

	// result forming
	assign sub       = px_q[2:0];
	assign scr_y     = {start_row_q, 3'b000} + 8'(idx_q);
	assign scr_base  = {3'b010, scr_y[7:6], scr_y[2:0], scr_y[5:3], 5'b00000};
	assign bcol      = is_right_q ? 6'(VIEW_COLS - 1) : 6'd0;
	assign last_line = is_row_q ? (idx_q == CNT_W'(VIEW_COLS))
		: (idx_q == CNT_W'(VIEW_HEIGHT - 1));

	always_comb begin
		res_d.last = last_line;
		if (is_row_q) begin
			res_d.kind        = tmer_pkg::KIND_ROW;
			res_d.screen_addr = '0;
			res_d.buffer_col  = 6'(idx_q);
			res_d.pixel_data  = tile_q;
			res_d.keep_mask   = '0;
		end else begin
			res_d.kind        = tmer_pkg::KIND_EDGE;
			res_d.screen_addr = scr_base + 16'(col_off_q) + 16'(bcol);
			res_d.buffer_col  = bcol;
			if (is_right_q) begin
				res_d.pixel_data = (tile_q >> (3'd6 - sub)) & tmer_pkg::RIGHT_PIX_MASK;
				res_d.keep_mask  = tmer_pkg::RIGHT_KEEP;
			end else begin
				res_d.pixel_data = (tile_q << sub) & tmer_pkg::LEFT_PIX_MASK;
				res_d.keep_mask  = tmer_pkg::LEFT_KEEP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	assign status.last_line = last_line;
	assign result           = result_q;
	assign result_strobe    = strobe_q;

endmodule
`default_nettype wire

// File: sv/tilemap_edge_and_row_renderer_unit.sv
// top level of the tilemap edge and row renderer: controller plus datapath
//
//   channel   handshake               payload
//   op        start / busy            op (tmer_pkg::op_t)
//   result    result_strobe           result (tmer_pkg::result_t)
//   config    cfg_we                  cfg_index, cfg_data
//
// map and tile writes happen on the transfer edge itself and leave busy low
// each result line steps through map read, tile read and result register
// edge commands produce VIEW_HEIGHT result lines, row commands VIEW_COLS+1
// a result shows in the cycle after its line finishes; the receiver cannot stall
// reset clears controller, line counter and strobe, presets config registers; stores not cleared
`default_nettype none
module tilemap_edge_and_row_renderer_unit #(
	parameter int MAP_COLS    = tmer_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS    = tmer_pkg::MAP_ROWS_DEF,
	parameter int VIEW_HEIGHT = tmer_pkg::VIEW_HEIGHT_DEF,
	parameter int VIEW_COLS   = tmer_pkg::VIEW_COLS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  tmer_pkg::op_t      op,
	output logic               result_strobe,
	output tmer_pkg::result_t  result,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [4:0]         cfg_data
);

	tmer_pkg::dp_cmd_t    cmd;
	tmer_pkg::dp_status_t status;

	tmer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (op.func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tmer_datapath #(
		.MAP_COLS    (MAP_COLS),
		.MAP_ROWS    (MAP_ROWS),
		.VIEW_HEIGHT (VIEW_HEIGHT),
		.VIEW_COLS   (VIEW_COLS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
`default_nettype wire

// File: sim/tilemap_edge_and_row_renderer_unit_tb.sv
// testbench: preloads the map and tile stores, then checks edge and row commands against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tilemap_edge_and_row_renderer_unit_tb;
	import tmer_pkg::*;

	localparam int MAP_COLS    = MAP_COLS_DEF;
	localparam int MAP_ROWS    = MAP_ROWS_DEF;
	localparam int VIEW_HEIGHT = VIEW_HEIGHT_DEF;
	localparam int VIEW_COLS   = VIEW_COLS_DEF;
	localparam int MAP_CELLS   = MAP_COLS * MAP_ROWS;
	localparam int PHASE_ITEMS = 10;
	// map rows an edge command can reach
	localparam int EDGE_ROWS   = 32;
	// first map column a row command may read
	localparam int ROW_COL_LO  = MAP_COLS - VIEW_COLS - 1;
	// edge commands from these columns on read the last map column
	localparam int LEFT_X_HI   = (MAP_COLS - 1) * 8;
	localparam int RIGHT_X_LO  = (MAP_COLS - 1) * 8 - (VIEW_COLS * 8 - 2);

	class render_scoreboard;
		logic [7:0] map_mem [MAP_CELLS];
		logic [7:0] tile_mem [TILE_SIZE];
		logic [4:0] start_row;
		logic [4:0] col_offset;
		result_t pending_results [$];
		int errors;

		function new();
			start_row = START_ROW_RST;
			col_offset = COL_OFFSET_RST;
			errors = 0;
		endfunction

		function void set_viewport(logic [4:0] row, logic [4:0] offset);
			start_row = row;
			col_offset = offset;
		endfunction

		function int tile_byte_at(int row, int col, int line);
			int r;
			int c;
			r = (row > MAP_ROWS - 1) ? MAP_ROWS - 1 : row;
			c = (col > MAP_COLS - 1) ? MAP_COLS - 1 : col;
			return tile_mem[{map_mem[r * MAP_COLS + c], 3'(line)}];
		endfunction

		function int screen_addr_of(int line, int col);
			int y;
			int a;
			y = (start_row * 8 + line) & 'hFF;
			a = 'h4000 | ((y & 'hC0) << 5) | ((y & 'h07) << 8) | ((y & 'h38) << 2);
			return (a + col_offset + col) & 'hFFFF;
		endfunction

		// predicts the results of one accepted transfer
		function void note_transfer(op_t item);
			result_t r;
			bit right;
			int i;
			int px;
			int tcol;
			int sub;
			int bcol;
			int my;
			int tb;
			case (item.func)
				FUNC_WR_MAP: begin
					if (item.table_addr < MAP_CELLS)
						map_mem[item.table_addr] = item.write_data;
				end
				FUNC_WR_TILE: begin
					if (item.table_addr < TILE_SIZE)
						tile_mem[item.table_addr[TILE_AW-1:0]] = item.write_data;
				end
				FUNC_EDGE_LEFT, FUNC_EDGE_RGHT: begin
					right = (item.func == FUNC_EDGE_RGHT);
					px = int'({item.view_x[9:1], 1'b0});
					if (right)
						px = px + VIEW_COLS * 8 - 2;
					tcol = px >> 3;
					sub = px & 7;
					bcol = right ? VIEW_COLS - 1 : 0;
					for (i = 0; i < VIEW_HEIGHT; i++) begin
						my = (item.view_y + i) & 'hFF;
						tb = tile_byte_at(my >> 3, tcol, my & 7);
						r.kind = KIND_EDGE;
						r.screen_addr = 16'(screen_addr_of(i, bcol));
						r.buffer_col = 6'(bcol);
						r.pixel_data = right ? 8'((tb >> (6 - sub)) & RIGHT_PIX_MASK)
							: 8'((tb << sub) & LEFT_PIX_MASK);
						r.keep_mask = right ? RIGHT_KEEP : LEFT_KEEP;
						r.last = (i == VIEW_HEIGHT - 1);
						pending_results.push_back(r);
					end
				end
				FUNC_ROW: begin
					for (i = 0; i <= VIEW_COLS; i++) begin
						r.kind = KIND_ROW;
						r.screen_addr = '0;
						r.buffer_col = 6'(i);
						r.pixel_data = 8'(tile_byte_at(item.row_tile, item.first_col + i,
							item.row_line));
						r.keep_mask = '0;
						r.last = (i == VIEW_COLS);
						pending_results.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string what, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("screen_addr", want.screen_addr, got.screen_addr);
			compare_field("buffer_col", want.buffer_col, got.buffer_col);
			compare_field("pixel_data", want.pixel_data, got.pixel_data);
			compare_field("keep_mask", want.keep_mask, got.keep_mask);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	op_t op = '0;
	logic result_strobe;
	result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_START_ROW;
	logic [4:0] cfg_data = '0;

	render_scoreboard board;
	int burst_left = 0;

	tilemap_edge_and_row_renderer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			board.check_result(result);
	end

	// the few tiles that map entries point at
	function automatic logic [7:0] used_tile(int k);
		case (k & 3)
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h5A;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic op_t random_op(logic [2:0] f);
		logic [63:0] raw;
		op_t o;
		raw = {$urandom, $urandom};
		o = raw[$bits(op_t)-1:0];
		o.func = f;
		return o;
	endfunction

	task automatic send_op(input op_t item);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_transfer(item);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_viewport(input logic [4:0] row, input logic [4:0] offset);
		cfg_we <= 1'b1;
		cfg_index <= CFG_START_ROW;
		cfg_data <= row;
		@(posedge clk);
		cfg_index <= CFG_COL_OFFSET;
		cfg_data <= offset;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_viewport(row, offset);
	endtask

	// render commands only read the preloaded map cells and tiles
	function automatic op_t random_item();
		op_t o;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			o = random_op(FUNC_WR_MAP);
			o.write_data = used_tile($urandom);
			if ($urandom_range(0, 9) != 0)
				o.table_addr = 13'($urandom_range(0, MAP_CELLS - 1));
		end else if (pick < 50) begin
			o = random_op(FUNC_WR_TILE);
			if ($urandom_range(0, 6) != 0)
				o.table_addr = 13'({used_tile($urandom), 3'($urandom)});
		end else if (pick < 67) begin
			o = random_op(FUNC_EDGE_LEFT);
			if ($urandom_range(0, 1) != 0)
				o.view_x = 10'($urandom_range(0, 7));
			else
				o.view_x = 10'($urandom_range(LEFT_X_HI, 1023));
		end else if (pick < 84) begin
			o = random_op(FUNC_EDGE_RGHT);
			o.view_x = 10'($urandom_range(RIGHT_X_LO, 1023));
		end else if (pick < 96) begin
			o = random_op(FUNC_ROW);
			o.first_col = 7'($urandom_range(ROW_COL_LO, 127));
			if ($urandom_range(0, 1) != 0)
				o.row_tile = '0;
			else
				o.row_tile = 6'($urandom_range(MAP_ROWS - 1, 63));
		end else begin
			o = random_op(FUNC_ROW + 3'($urandom_range(1, 3)));
		end
		return o;
	endfunction

	initial begin
		op_t item;
		int a;
		int p;
		int sent;
		int phase_row [5] = '{0, 23, 31, 9, 0};
		int phase_off [5] = '{0, 31, 17, 0, 0};
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the tiles and map cells that commands read
		for (a = 0; a < 32; a++) begin
			item = random_op(FUNC_WR_TILE);
			item.table_addr = 13'({used_tile(a >> 3), 3'(a)});
			send_op(item);
		end
		for (a = 0; a < EDGE_ROWS; a++) begin
			item = random_op(FUNC_WR_MAP);
			item.table_addr = 13'(a * MAP_COLS);
			item.write_data = used_tile($urandom);
			send_op(item);
			item = random_op(FUNC_WR_MAP);
			item.table_addr = 13'(a * MAP_COLS + MAP_COLS - 1);
			item.write_data = used_tile($urandom);
			send_op(item);
		end
		for (a = ROW_COL_LO; a < MAP_COLS; a++) begin
			item = random_op(FUNC_WR_MAP);
			item.table_addr = 13'(a);
			item.write_data = used_tile($urandom);
			send_op(item);
			item = random_op(FUNC_WR_MAP);
			item.table_addr = 13'((MAP_ROWS - 1) * MAP_COLS + a);
			item.write_data = used_tile($urandom);
			send_op(item);
		end

		// directed: field extremes, odd camera column, wrap, clamps, ignored writes
		item = random_op(FUNC_EDGE_LEFT); item.view_x = 0; item.view_y = 0; send_op(item);
		item = random_op(FUNC_EDGE_LEFT); item.view_x = '1; item.view_y = '1; send_op(item);
		item = random_op(FUNC_EDGE_LEFT); item.view_x = 3; item.view_y = 7; send_op(item);
		item = random_op(FUNC_EDGE_LEFT);
		item.view_x = 10'(LEFT_X_HI); item.view_y = 100; send_op(item);
		item = random_op(FUNC_EDGE_RGHT);
		item.view_x = 10'(RIGHT_X_LO); item.view_y = 0; send_op(item);
		item = random_op(FUNC_EDGE_RGHT); item.view_x = 767; item.view_y = '1; send_op(item);
		item = random_op(FUNC_EDGE_RGHT); item.view_x = '1; item.view_y = 128; send_op(item);
		item = random_op(FUNC_ROW);
		item.first_col = 7'(ROW_COL_LO); item.row_tile = 0; item.row_line = 0; send_op(item);
		item = random_op(FUNC_ROW);
		item.first_col = 7'(MAP_COLS - 1); item.row_tile = 6'(MAP_ROWS - 1); item.row_line = '1;
		send_op(item);
		item = random_op(FUNC_ROW);
		item.first_col = '1; item.row_tile = '1; item.row_line = 3; send_op(item);
		item = random_op(FUNC_WR_MAP); item.table_addr = 13'(MAP_CELLS); send_op(item);
		item = random_op(FUNC_WR_MAP); item.table_addr = '1; send_op(item);
		item = random_op(FUNC_WR_TILE); item.table_addr = 13'(TILE_SIZE); send_op(item);
		item = random_op(FUNC_WR_TILE); item.table_addr = '1; send_op(item);
		item = random_op(FUNC_WR_MAP); item.table_addr = 0; item.write_data = 0; send_op(item);
		item = random_op(FUNC_WR_MAP);
		item.table_addr = 13'(MAP_CELLS - 1); item.write_data = '1; send_op(item);
		item = random_op(FUNC_WR_TILE); item.table_addr = 0; item.write_data = '1; send_op(item);
		item = random_op(FUNC_WR_TILE);
		item.table_addr = 13'(TILE_SIZE - 1); item.write_data = 0; send_op(item);
		item = random_op(FUNC_ROW);
		item.first_col = 7'(ROW_COL_LO); item.row_tile = 0; item.row_line = 0; send_op(item);
		item = random_op(FUNC_EDGE_RGHT); item.view_x = 766; item.view_y = 248; send_op(item);
		item = random_op(FUNC_EDGE_LEFT); item.view_x = 0; item.view_y = 0; send_op(item);
		for (a = 1; a <= 3; a++) begin
			item = random_op(FUNC_ROW + 3'(a));
			send_op(item);
		end
		drain();

		for (p = 0; p < 5; p++) begin
			if (p == 4)
				write_viewport(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			else
				write_viewport(5'(phase_row[p]), 5'(phase_off[p]));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				item = random_item();
				send_op(item);
				if (item.func <= FUNC_ROW)
					sent++;
			end
			drain();
		end

		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("tilemap_edge_and_row_renderer_unit test passed");
		else
			$display("tilemap_edge_and_row_renderer_unit test failed");
		$finish;
	end

	initial begin
		#16000000;
		$display("tilemap_edge_and_row_renderer_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
sv/tmer_pkg.sv
sv/tmer_ctrl.sv
sv/tmer_datapath.sv
sv/tilemap_edge_and_row_renderer_unit.sv
sim/tilemap_edge_and_row_renderer_unit_tb.sv
